>>> design/sepd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sepd_pkg
// Shared types and codes for the sync/escape packet deframer.
// ----------------------------------------------------------------------------
package sepd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned CFG_IDX_W = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_CODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE = 1'd1;

    localparam logic [BYTE_W-1:0] SYNC_CODE_RST   = 8'hE0;
    localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'hD0;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DEST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LEN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd3;

    // frame end status
    localparam logic [STATUS_W-1:0] ST_GOOD    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADSUM  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZEROLEN = 2'd2;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_DEST = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2,
        PH_IDLE = 2'd3
    } t_phase;

    // classified byte passed from front to back
    typedef struct packed {
        logic              is_sync;
        logic [BYTE_W-1:0] value;
    } t_token;

endpackage
`default_nettype wire

>>> design/sepd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sepd_front
// Holds the sync/escape codes, tracks escapes and classifies each line byte
// into a sync marker or an unescaped data byte.
// ----------------------------------------------------------------------------
module sepd_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [sepd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [sepd_pkg::BYTE_W-1:0]    i_cfg_data,
    input  wire logic                           i_accept,
    input  wire logic [sepd_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                                o_push,
    output sepd_pkg::t_token                    o_token
);
    import sepd_pkg::*;

    logic [BYTE_W-1:0] r_sync_code;
    logic [BYTE_W-1:0] r_escape_code;
    logic              r_esc_pending;
    logic              n_esc_pending;
    logic              hit_sync;
    logic              hit_escape;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_code   <= SYNC_CODE_RST;
            r_escape_code <= ESCAPE_CODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SYNC_CODE:   r_sync_code   <= i_cfg_data;
                CFG_ESCAPE_CODE: r_escape_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        hit_sync   = !r_esc_pending && (i_rx_byte == r_sync_code);
        hit_escape = !r_esc_pending && (i_rx_byte == r_escape_code) && !hit_sync;

        n_esc_pending = r_esc_pending;
        if (i_accept && !hit_sync)
            n_esc_pending = hit_escape;

        // escape bytes are swallowed
        o_push          = i_accept && !hit_escape;
        o_token.is_sync = hit_sync;
        o_token.value   = r_esc_pending ? i_rx_byte + BYTE_W'(1) : i_rx_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_pending <= 1'b0;
        end else begin
            r_esc_pending <= n_esc_pending;
        end
    end

endmodule
`default_nettype wire

>>> design/sepd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sepd_queue
// Short token queue that decouples the classifier from the frame sequencer.
// ----------------------------------------------------------------------------
module sepd_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire sepd_pkg::t_token i_token,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output sepd_pkg::t_token      o_token
);
    import sepd_pkg::*;

    t_token              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr;
    logic [QPTR_W-1:0]   r_rptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wptr] <= i_token;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push)
                r_wptr <= r_wptr + QPTR_W'(1);
            if (i_pop)
                r_rptr <= r_rptr + QPTR_W'(1);
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> design/sepd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sepd_back
// Frame sequencer: walks destination, length, payload and checksum, keeps
// the running sum and drives the registered result.
// ----------------------------------------------------------------------------
module sepd_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_tok_valid,
    input  wire sepd_pkg::t_token              i_token,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [sepd_pkg::KIND_W-1:0]        o_item_kind,
    output logic [sepd_pkg::BYTE_W-1:0]        o_item_value,
    output logic [sepd_pkg::STATUS_W-1:0]      o_frame_status,
    output logic                               o_frame_last
);
    import sepd_pkg::*;

    t_phase              r_phase, n_phase;
    logic [BYTE_W-1:0]   r_sum, n_sum;
    logic [BYTE_W-1:0]   r_len, n_len;
    logic [BYTE_W-1:0]   r_cnt, n_cnt;

    logic                r_out_valid;
    logic [KIND_W-1:0]   r_kind;
    logic [BYTE_W-1:0]   r_value;
    logic [STATUS_W-1:0] r_status;
    logic                r_last;

    logic                emit;
    logic [KIND_W-1:0]   e_kind;
    logic [BYTE_W-1:0]   e_value;
    logic [STATUS_W-1:0] e_status;
    logic                e_last;
    logic [BYTE_W-1:0]   b;
    logic                last_byte;

    assign o_pop = i_tok_valid && (!r_out_valid || !i_out_stall);
    assign b     = i_token.value;
    // payload count stays below length, so a 9-bit compare is exact
    assign last_byte = ({1'b0, r_cnt} + 9'd1) == {1'b0, r_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DEST;
            r_sum   <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_sum    = r_sum;
        n_len    = r_len;
        n_cnt    = r_cnt;
        emit     = 1'b0;
        e_kind   = KIND_DEST;
        e_value  = b;
        e_status = ST_GOOD;
        e_last   = 1'b0;
        if (o_pop) begin
            if (i_token.is_sync) begin
                n_phase = PH_DEST;
                n_cnt   = '0;
            end else begin
                unique case (r_phase)
                    PH_DEST: begin
                        n_sum   = b;
                        n_phase = PH_LEN;
                        emit    = 1'b1;
                        e_kind  = KIND_DEST;
                    end
                    PH_LEN: begin
                        n_len = b;
                        n_sum = r_sum + b;
                        emit  = 1'b1;
                        if (b == '0) begin
                            n_phase  = PH_IDLE;
                            e_kind   = KIND_END;
                            e_value  = '0;
                            e_status = ST_ZEROLEN;
                            e_last   = 1'b1;
                        end else begin
                            n_cnt   = '0;
                            n_phase = PH_BODY;
                            e_kind  = KIND_LEN;
                        end
                    end
                    PH_BODY: begin
                        emit = 1'b1;
                        if (last_byte) begin
                            n_phase  = PH_IDLE;
                            e_kind   = KIND_END;
                            e_value  = '0;
                            e_status = (r_sum == b) ? ST_GOOD : ST_BADSUM;
                            e_last   = 1'b1;
                        end else begin
                            n_sum  = r_sum + b;
                            n_cnt  = r_cnt + BYTE_W'(1);
                            e_kind = KIND_DATA;
                        end
                    end
                    PH_IDLE: ;
                    default: ;
                endcase
            end
        end
    end

    // output register: loads whenever the sequencer emits, drains on !stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind   <= e_kind;
            r_value  <= e_value;
            r_status <= e_status;
            r_last   <= e_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_item_kind    = r_kind;
    assign o_item_value   = r_value;
    assign o_frame_status = r_status;
    assign o_frame_last   = r_last;

endmodule
`default_nettype wire

>>> design/sync_escape_packet_deframer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sync_escape_packet_deframer_core
// Splits a serial byte stream into destination, length, payload and
// frame-end results with checksum check.
// ----------------------------------------------------------------------------
// Accepts one line byte per clock while o_in_stall is low. A byte is
// classified (sync, escape, data) in the front, queued in a two-entry token
// queue, and sequenced in the back, whose result is registered in an output
// register when the sequencer pops the byte. Sustained rate is one byte per
// cycle while the output is not stalled, set by the phase/sum update in the
// sequencer; input stall rises only when the queue fills behind a stalled
// output. The user must write the sync and escape codes through the
// configuration port only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module sync_escape_packet_deframer_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [sepd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [sepd_pkg::BYTE_W-1:0]    i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [sepd_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [sepd_pkg::KIND_W-1:0]         o_item_kind,
    output logic [sepd_pkg::BYTE_W-1:0]         o_item_value,
    output logic [sepd_pkg::STATUS_W-1:0]       o_frame_status,
    output logic                                o_frame_last
);
    import sepd_pkg::*;

    logic   full;
    logic   accept;
    logic   push;
    t_token push_tok;
    logic   pop;
    logic   q_valid;
    t_token q_tok;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    sepd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .o_push      (push),
        .o_token     (push_tok)
    );

    sepd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (push_tok),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_token (q_tok)
    );

    sepd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tok_valid    (q_valid),
        .i_token        (q_tok),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_item_kind    (o_item_kind),
        .o_item_value   (o_item_value),
        .o_frame_status (o_frame_status),
        .o_frame_last   (o_frame_last)
    );

endmodule
`default_nettype wire
